[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CFD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: assertion failed");

// Same check, but also evaluated while reset is applied.
`define CFD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("%m: assertion failed");

`endif

[sv/cfd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfd_pkg
// Constants, types and the CRC16 byte update for the frame deframer.
// ---------------------------------------------------------------------------
package cfd_pkg;

	localparam int unsigned BUFFER_BYTES = 256;
	// byte counter is 8 bits, so the buffer limit tops out at 256
	localparam int unsigned LIMIT = (BUFFER_BYTES > 256) ? 256 : BUFFER_BYTES;
	localparam logic [7:0] COUNT_STOP = 8'(LIMIT - 1);

	localparam logic [7:0]  HDR0         = 8'hA5;
	localparam logic [7:0]  HDR1         = 8'hB6;
	localparam logic [15:0] BROADCAST    = 16'hFFFF;
	localparam logic [7:0]  MIN_FRAME    = 8'd13;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [15:0] ADDR_RESET   = 16'h0001;

	// frame offsets of header fields
	localparam logic [7:0] OFS_ADDR_HI  = 8'd2;
	localparam logic [7:0] OFS_ADDR_LO  = 8'd3;
	localparam logic [7:0] OFS_PLEN     = 8'd7;
	localparam logic [7:0] CRC_LAG      = 8'd4;

	typedef enum logic [2:0] {
		VD_NONE     = 3'd0,
		VD_ACCEPT   = 3'd1,
		VD_CRC_ERR  = 3'd2,
		VD_LEN_ERR  = 3'd3,
		VD_ID_DROP  = 3'd4,
		VD_SHORT    = 3'd5,
		VD_OVERFLOW = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [15:0] frame_address;
		logic [7:0]  payload_length;
		logic [7:0]  frame_length;
		verdict_t    verdict;
		logic [7:0]  position;
		logic        in_frame;
		logic [7:0]  echo_byte;
	} result_t;

	// CRC16-Modbus, reflected, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
	                                           input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[sv/cfd_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfd_core
// Header hunt, frame state, running CRC and trailer judgment per byte.
// ---------------------------------------------------------------------------
module cfd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte,
	input  logic [15:0]      device_address,
	output cfd_pkg::result_t result
);
	import cfd_pkg::*;

	typedef enum logic [2:0] {
		PH_SEEK_HDR0 = 3'b001,
		PH_SEEK_HDR1 = 3'b010,
		PH_COLLECT   = 3'b100
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  recent_q [4];
	logic [7:0]  recent_d [4];
	logic [15:0] addr_q, addr_d;
	logic [7:0]  plen_q, plen_d;

	// values after shifting rx_byte into the frame
	logic [15:0] crc_push;
	logic [15:0] addr_push;
	logic [7:0]  plen_push;
	logic [7:0]  frame_len;
	logic [15:0] rx_crc;
	logic        trailer;

	always_comb begin
		crc_push  = (count_q >= CRC_LAG) ? crc16_byte(crc_q, recent_q[3]) : crc_q;
		addr_push = addr_q;
		plen_push = plen_q;
		if (count_q == OFS_ADDR_HI) begin
			addr_push = {rx_byte, addr_q[7:0]};
		end else if (count_q == OFS_ADDR_LO) begin
			addr_push = {addr_q[15:8], rx_byte};
		end else if (count_q == OFS_PLEN) begin
			plen_push = rx_byte;
		end
		frame_len = count_q + 8'd1;
		rx_crc    = {recent_q[2], recent_q[1]};
		trailer   = (recent_q[0] == HDR1) && (rx_byte == HDR0);
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		crc_d   = crc_q;
		addr_d  = addr_q;
		plen_d  = plen_q;
		for (int i = 0; i < 4; i++) begin
			recent_d[i] = recent_q[i];
		end

		result                = '0;
		result.echo_byte      = rx_byte;
		result.verdict        = VD_NONE;

		unique case (phase_q)
			PH_SEEK_HDR1: begin
				if (rx_byte == HDR1) begin
					crc_d       = crc_push;
					recent_d[3] = recent_q[2];
					recent_d[2] = recent_q[1];
					recent_d[1] = recent_q[0];
					recent_d[0] = rx_byte;
					addr_d      = addr_push;
					plen_d      = plen_push;
					count_d     = frame_len;
					phase_d     = PH_COLLECT;
					result.in_frame = 1'b1;
					result.position = count_q;
				end else if (rx_byte == HDR0) begin
					// repeated A5 restarts the header
					crc_d   = CRC_INIT;
					addr_d  = '0;
					plen_d  = '0;
					recent_d[0] = HDR0;
					recent_d[1] = '0;
					recent_d[2] = '0;
					recent_d[3] = '0;
					count_d = 8'd1;
					phase_d = PH_SEEK_HDR1;
					result.in_frame = 1'b1;
				end else begin
					phase_d = PH_SEEK_HDR0;
					count_d = '0;
				end
			end
			PH_COLLECT: begin
				if (count_q >= COUNT_STOP) begin
					result.verdict = VD_OVERFLOW;
					phase_d = PH_SEEK_HDR0;
					count_d = '0;
				end else begin
					crc_d       = crc_push;
					recent_d[3] = recent_q[2];
					recent_d[2] = recent_q[1];
					recent_d[1] = recent_q[0];
					recent_d[0] = rx_byte;
					addr_d      = addr_push;
					plen_d      = plen_push;
					count_d     = frame_len;
					result.in_frame = 1'b1;
					result.position = count_q;
					if (trailer) begin
						result.frame_length   = frame_len;
						result.payload_length = plen_push;
						result.frame_address  = addr_push;
						priority if (frame_len < MIN_FRAME) begin
							result.verdict = VD_SHORT;
						end else if (crc_push != rx_crc) begin
							result.verdict = VD_CRC_ERR;
						end else if (addr_push != BROADCAST &&
						             addr_push != device_address) begin
							result.verdict = VD_ID_DROP;
						end else if (({1'b0, plen_push} + {1'b0, MIN_FRAME}) !=
						             {1'b0, frame_len}) begin
							result.verdict = VD_LEN_ERR;
						end else begin
							result.verdict = VD_ACCEPT;
						end
						phase_d = PH_SEEK_HDR0;
						count_d = '0;
					end
				end
			end
			default: begin
				// seeking the first header byte
				if (rx_byte == HDR0) begin
					crc_d   = CRC_INIT;
					addr_d  = '0;
					plen_d  = '0;
					recent_d[0] = HDR0;
					recent_d[1] = '0;
					recent_d[2] = '0;
					recent_d[3] = '0;
					count_d = 8'd1;
					phase_d = PH_SEEK_HDR1;
					result.in_frame = 1'b1;
				end else begin
					phase_d = PH_SEEK_HDR0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK_HDR0;
			count_q <= '0;
			crc_q   <= CRC_INIT;
			addr_q  <= '0;
			plen_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				recent_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			addr_q  <= addr_d;
			plen_q  <= plen_d;
			for (int i = 0; i < 4; i++) begin
				recent_q[i] <= recent_d[i];
			end
		end
	end

endmodule

[sv/crc_checked_frame_deframer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc_checked_frame_deframer
// Byte stream deframer with CRC16-Modbus and device id checks.
// ---------------------------------------------------------------------------
// Takes one received byte per word on the slave stream and returns exactly one
// result word per byte on the master stream, in the cycle after acceptance. A
// byte is accepted every cycle as long as the result register is empty or its
// word is taken in the same cycle, so sustained throughput is one byte per
// clock; the CRC16 byte update and the trailer checks are both combinational,
// between the frame state registers and the result register. Frames open
// with A5 B6 and close when the last two bytes are B6 A5. At the closing
// byte the result carries a verdict: short drop (under 13 bytes), CRC error,
// id drop (neither device_address nor broadcast FFFF), length error
// (payload length + 13 differs from frame length) or accept. A frame that
// fills the buffer ends with an overflow verdict on the byte that did not fit.
// Every result echoes its byte with the frame position so a downstream
// capture buffer can hold the frame until the verdict arrives.
// device_address resets to 0001; the user must write it via cfg_* only while
// no byte is in flight (not enforced); the write port is always ready.
// ---------------------------------------------------------------------------
module crc_checked_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,     // device_address
	// received bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // rx_byte
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,      // echo_byte, position, frame_length,
	                                  // payload_length, frame_address
	output logic [3:0]  m_tuser       // in_frame, verdict
);
	import cfd_pkg::*;

	logic [15:0] dev_addr_q;
	logic        out_valid_q;
	result_t     result_q;
	result_t     result_d;
	logic        advance;

	assign cfg_ready = 1'b1;

	// result register frees up when its word is taken
	assign s_tready = !out_valid_q || m_tready;
	assign advance  = s_tvalid && s_tready;

	cfd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.rx_byte        (s_tdata),
		.device_address (dev_addr_q),
		.result         (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {result_q.frame_address, result_q.payload_length,
	                   result_q.frame_length, result_q.position, result_q.echo_byte};
	assign m_tuser  = {result_q.verdict, result_q.in_frame};

endmodule

[sv/cfd_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [3:0]  m_tuser
);
	import cfd_pkg::*;

	// stalled result word holds
	`CFD_ASSERT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// an accepted byte shows up echoed in the next result word
	`CFD_ASSERT(a_echo, clk, arst_n, s_tvalid && s_tready |=> m_tvalid && (m_tdata[7:0] == $past(s_tdata)))

	// bytes not stored sit at position 0 and close no frame judged on length
	`CFD_ASSERT(a_unstored, clk, arst_n, m_tvalid && !m_tuser[0] |-> (m_tdata[15:8] == 8'd0) && (m_tuser[3:1] == VD_NONE || m_tuser[3:1] == VD_OVERFLOW))

	// an accepted frame has a consistent length
	`CFD_ASSERT(a_accept_len, clk, arst_n, m_tvalid && m_tuser[3:1] == VD_ACCEPT |-> ({1'b0, m_tdata[31:24]} + {1'b0, MIN_FRAME}) == {1'b0, m_tdata[23:16]})

endmodule

bind crc_checked_frame_deframer cfd_checker u_cfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[test/tb_crc_checked_frame_deframer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_crc_checked_frame_deframer
// Self-checking bench for the CRC16-Modbus frame deframer.
// ---------------------------------------------------------------------------
// Received bytes are pushed into a send queue by the sequencing block below.
// A bursty driver offers them on the slave stream at the falling edge. The
// monitor runs at the rising edge. For every accepted byte it runs a local
// deframer model and queues the result word it predicts. Every result word
// the block returns is checked field by field against the oldest prediction.
// The run covers four device id settings: reset value, 0000, FFFF and a
// random id. Stimulus is mostly well-formed frames with random content, mixed
// with CRC and length faults, short frames, header restarts, cut frames,
// overflow and noise.
// ---------------------------------------------------------------------------
module tb_crc_checked_frame_deframer;
	import cfd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {
		HUNT_A5,
		HUNT_B6,
		COLLECT
	} hunt_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_LEN
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [3:0]  m_tuser;

	crc_checked_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	// send queue and predicted result words
	logic [7:0] rx_bytes_q[$];
	result_t    deframed_q[$];
	int         bytes_queued = 0;
	int         errors = 0;
	int         cycles = 0;

	// model state of the deframer
	hunt_t       hunt_state = HUNT_A5;
	logic [7:0]  fill_count = 8'd0;
	logic [15:0] crc_acc = CRC_INIT;
	logic [7:0]  tail [0:3];          // last four stored bytes, newest at 0
	logic [15:0] got_addr = 16'h0000;
	logic [7:0]  got_plen = 8'd0;
	logic [15:0] own_addr = ADDR_RESET;

	// driver and receiver state
	logic       holding = 1'b0;       // a byte is on the slave stream
	logic       in_took = 1'b0;       // set at the edge where it was taken
	logic [7:0] cur_byte = 8'h00;
	int         burst_left = 0;
	int         gap_left = 0;
	int         rdy_mode = 0;
	int         rdy_left = 0;
	logic [7:0] rdy_pat = 8'hFF;

	// bit-serial form of the reflected A001 update
	function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
	                                                input logic [7:0] d);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ d[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic void open_frame();
		crc_acc = CRC_INIT;
		got_addr = 16'h0000;
		got_plen = 8'd0;
		tail[0] = HDR0;
		tail[1] = 8'h00;
		tail[2] = 8'h00;
		tail[3] = 8'h00;
		fill_count = 8'd1;
		hunt_state = HUNT_B6;
	endfunction

	// store one byte; the CRC trails the newest byte by four places
	function automatic void take_byte(input logic [7:0] b);
		if (fill_count >= CRC_LAG) begin
			crc_acc = modbus_crc_step(crc_acc, tail[3]);
		end
		tail[3] = tail[2];
		tail[2] = tail[1];
		tail[1] = tail[0];
		tail[0] = b;
		if (fill_count == OFS_ADDR_HI) begin
			got_addr[15:8] = b;
		end else if (fill_count == OFS_ADDR_LO) begin
			got_addr[7:0] = b;
		end else if (fill_count == OFS_PLEN) begin
			got_plen = b;
		end
		fill_count = fill_count + 8'd1;
	endfunction

	function automatic result_t deframe_step(input logic [7:0] b);
		result_t     r;
		int unsigned flen;
		r = '0;
		r.echo_byte = b;
		r.verdict = VD_NONE;
		case (hunt_state)
			HUNT_B6: begin
				if (b == HDR1) begin
					take_byte(b);
					r.in_frame = 1'b1;
					r.position = 8'd1;
					hunt_state = COLLECT;
				end else if (b == HDR0) begin
					// repeated A5 restarts the header
					open_frame();
					r.in_frame = 1'b1;
				end else begin
					hunt_state = HUNT_A5;
					fill_count = 8'd0;
				end
			end
			COLLECT: begin
				if (fill_count >= COUNT_STOP) begin
					// buffer full: byte dropped with the frame
					r.verdict = VD_OVERFLOW;
					hunt_state = HUNT_A5;
					fill_count = 8'd0;
				end else begin
					r.position = fill_count;
					r.in_frame = 1'b1;
					take_byte(b);
					if (tail[1] == HDR1 && tail[0] == HDR0) begin
						flen = r.position + 1;
						r.frame_length = flen[7:0];
						r.payload_length = got_plen;
						r.frame_address = got_addr;
						if (flen < MIN_FRAME) begin
							r.verdict = VD_SHORT;
						end else if (crc_acc != {tail[3], tail[2]}) begin
							r.verdict = VD_CRC_ERR;
						end else if (got_addr != BROADCAST && got_addr != own_addr) begin
							r.verdict = VD_ID_DROP;
						end else if (int'(got_plen) + int'(MIN_FRAME) != flen) begin
							r.verdict = VD_LEN_ERR;
						end else begin
							r.verdict = VD_ACCEPT;
						end
						hunt_state = HUNT_A5;
						fill_count = 8'd0;
					end
				end
			end
			default: begin
				if (b == HDR0) begin
					open_frame();
					r.in_frame = 1'b1;
				end else begin
					hunt_state = HUNT_A5;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void report_mismatch(input string what, input result_t want,
	                                        input result_t seen);
		errors++;
		if (errors <= 10) begin
			$display("mismatch (%s) at %0t", what, $realtime);
			$display("    want byte %h in %b pos %0d vd %0d flen %0d plen %0d addr %h",
				want.echo_byte, want.in_frame, want.position, want.verdict,
				want.frame_length, want.payload_length, want.frame_address);
			$display("    got byte %h in %b pos %0d vd %0d flen %0d plen %0d addr %h",
				seen.echo_byte, seen.in_frame, seen.position, seen.verdict,
				seen.frame_length, seen.payload_length, seen.frame_address);
		end
	endfunction

	// ---------------- stimulus builders ----------------

	function automatic void queue_byte(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_queued++;
	endfunction

	// frame content never carries A5, so no early trailer inside it
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == HDR0) begin
			b = 8'h5A;
		end
		return b;
	endfunction

	function automatic logic [7:0] noise_byte();
		int p;
		p = $urandom_range(0, 3);
		if (p == 0) begin
			return HDR0;
		end else if (p == 1) begin
			return HDR1;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_addr();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) begin
			return own_addr;
		end else if (p < 65) begin
			return BROADCAST;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// mostly small payloads, now and then a long one
	function automatic logic [7:0] pick_plen();
		if ($urandom_range(0, 39) == 0) begin
			return 8'($urandom_range(13, 242));
		end
		return 8'($urandom_range(0, 12));
	endfunction

	// layout: A5 B6, id hi/lo, three bytes, plen, plen+1 body bytes, CRC hi/lo, B6 A5
	function automatic void queue_frame(input logic [15:0] addr, input logic [7:0] plen,
	                                    input frame_kind_t kind);
		logic [7:0]  f[$];
		logic [15:0] c;
		int          body;
		int          tries;
		bit          clean;
		tries = 0;
		do begin
			f = {};
			body = int'(plen) + 1;
			if (kind == FR_BAD_LEN) begin
				body = $urandom_range(0, 24);
				if (body == int'(plen) + 1) begin
					body++;
				end
			end
			f.push_back(HDR0);
			f.push_back(HDR1);
			f.push_back(addr[15:8]);
			f.push_back(addr[7:0]);
			repeat (3) f.push_back(body_byte());
			f.push_back(plen);
			repeat (body) f.push_back(body_byte());
			c = CRC_INIT;
			foreach (f[i]) begin
				c = modbus_crc_step(c, f[i]);
			end
			if (kind == FR_BAD_CRC) begin
				c = c ^ (16'h0001 << $urandom_range(0, 15));
			end
			f.push_back(c[15:8]);
			f.push_back(c[7:0]);
			f.push_back(HDR1);
			f.push_back(HDR0);
			// CRC or id bytes may still form B6 A5 early; retry a few times
			clean = 1'b1;
			for (int i = 2; i < f.size() - 1; i++) begin
				if (f[i - 1] == HDR1 && f[i] == HDR0) begin
					clean = 1'b0;
				end
			end
			tries++;
		end while (!clean && tries < 8);
		foreach (f[i]) begin
			queue_byte(f[i]);
		end
	endfunction

	function automatic void queue_traffic(input int budget);
		int stop;
		int p;
		stop = bytes_queued + budget;
		while (bytes_queued < stop) begin
			p = $urandom_range(0, 99);
			if (p < 52) begin
				queue_frame(pick_addr(), pick_plen(), FR_GOOD);
			end else if (p < 60) begin
				queue_frame(pick_addr(), pick_plen(), FR_BAD_CRC);
			end else if (p < 68) begin
				queue_frame(pick_addr(), 8'($urandom_range(0, 255)), FR_BAD_LEN);
			end else if (p < 76) begin
				// trailer before 13 bytes
				queue_byte(HDR0);
				queue_byte(HDR1);
				repeat ($urandom_range(0, 8)) queue_byte(body_byte());
				queue_byte(HDR1);
				queue_byte(HDR0);
			end else if (p < 84) begin
				// cut frame: runs on into whatever follows
				queue_byte(HDR0);
				queue_byte(HDR1);
				repeat ($urandom_range(0, 8)) queue_byte(body_byte());
			end else if (p < 92) begin
				// extra A5 bytes before a frame restart the header
				repeat ($urandom_range(1, 3)) queue_byte(HDR0);
				queue_frame(pick_addr(), pick_plen(), FR_GOOD);
			end else begin
				repeat ($urandom_range(1, 8)) queue_byte(noise_byte());
			end
		end
	endfunction

	// ---------------- sequencing ----------------

	// wait until every byte is taken and every result word is back
	task automatic settle();
		while (rx_bytes_q.size() != 0 || holding || deframed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_device_address(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		own_addr = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, dropped header, restart into a 3-byte
		// short frame, then a minimal good frame for the reset id
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(HDR0);
		queue_byte(8'h00);
		queue_byte(HDR0);
		queue_byte(HDR0);
		queue_byte(HDR1);
		queue_byte(HDR0);
		queue_frame(ADDR_RESET, 8'd0, FR_GOOD);
		queue_traffic(220);
		settle();

		// id 0000: overflow and a frame of the largest size
		set_device_address(16'h0000);
		queue_byte(HDR0);
		queue_byte(HDR1);
		repeat (260) queue_byte(body_byte());
		queue_frame(BROADCAST, 8'd242, FR_GOOD);
		queue_frame(16'h0000, 8'd5, FR_GOOD);
		queue_frame(16'h1234, 8'd3, FR_GOOD);
		queue_traffic(150);
		settle();

		set_device_address(16'hFFFF);
		queue_traffic(220);
		settle();

		set_device_address(16'($urandom_range(0, 65535)));
		queue_traffic(250);
		settle();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// ---------------- driver ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_took) begin
				holding = 1'b0;
				in_took = 1'b0;
			end
			if (!holding) begin
				if (burst_left == 0) begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
				if (burst_left > 0 && rx_bytes_q.size() > 0) begin
					cur_byte = rx_bytes_q.pop_front();
					holding = 1'b1;
					burst_left--;
				end
			end
			s_tvalid <= holding;
			s_tdata <= cur_byte;
		end
	end

	// receiver: stretches of always-ready, random, rotating pattern, long stalls
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(20, 120);
			rdy_pat = 8'($urandom_range(0, 255)) | 8'h01;
		end else begin
			rdy_left--;
		end
		case (rdy_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: begin
				m_tready <= rdy_pat[0];
				rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
			end
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin : monitor
		result_t seen;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.echo_byte = m_tdata[7:0];
				seen.position = m_tdata[15:8];
				seen.frame_length = m_tdata[23:16];
				seen.payload_length = m_tdata[31:24];
				seen.frame_address = m_tdata[47:32];
				seen.in_frame = m_tuser[0];
				seen.verdict = verdict_t'(m_tuser[3:1]);
				if (deframed_q.size() == 0) begin
					report_mismatch("no word pending", '0, seen);
				end else begin
					want = deframed_q.pop_front();
					if (seen.echo_byte !== want.echo_byte ||
					    seen.in_frame !== want.in_frame ||
					    seen.position !== want.position ||
					    seen.verdict !== want.verdict ||
					    seen.frame_length !== want.frame_length ||
					    seen.payload_length !== want.payload_length ||
					    seen.frame_address !== want.frame_address) begin
						report_mismatch("field", want, seen);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				deframed_q.push_back(deframe_step(s_tdata));
				in_took = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
